/* src/assert_macros.svh */
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clock edge outside reset.
`define SVM_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must hold in the cycle after a trigger.
`define SVM_ASSERT_NEXT(label, trig, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) trig |=> post) else $error(msg);

`endif

/* src/svm_pkg.sv */
`default_nettype none

package svm_pkg;

  localparam int VOICES           = 4;
  localparam int SAMPLE_ADDR_BITS = 16;
  localparam int SMEM_DEPTH       = 1 << SAMPLE_ADDR_BITS;
  localparam int VIDX_W           = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam int LIM_W            = $clog2(VOICES + 1);

  localparam logic [31:0] STEP_INCREMENT = 32'd65536;
  localparam logic [6:0]  VOL_MAX        = 7'd64;
  localparam logic [15:0] LOOP_MIN       = 16'd2;
  localparam logic [2:0]  ACTIVE_RESET   = 3'd4;

  localparam logic [2:0] CMD_WRITE  = 3'd0;
  localparam logic [2:0] CMD_START  = 3'd1;
  localparam logic [2:0] CMD_STOP   = 3'd2;
  localparam logic [2:0] CMD_VOLUME = 3'd3;
  localparam logic [2:0] CMD_PAN    = 3'd4;
  localparam logic [2:0] CMD_RATE   = 3'd5;
  localparam logic [2:0] CMD_MIX    = 3'd6;

  typedef struct packed {
    logic        playing;
    logic [15:0] cursor;
    logic [31:0] acc;
    logic [15:0] base;
    logic [15:0] length;
    logic [15:0] loop_start;
    logic [15:0] loop_length;
    logic [6:0]  volume;
    logic [31:0] rate;
    logic        pan_left;
  } voice_t;

  localparam voice_t VOICE_RESET = '{
    playing:     1'b0,
    cursor:      16'd0,
    acc:         32'd0,
    base:        16'd0,
    length:      16'd0,
    loop_start:  16'd0,
    loop_length: 16'd0,
    volume:      7'd0,
    rate:        32'hFFFF_FFFF,
    pan_left:    1'b0
  };

  function automatic logic [6:0] clamp_volume(input logic [6:0] v);
    return (v > VOL_MAX) ? VOL_MAX : v;
  endfunction

endpackage

`default_nettype wire

/* src/svm_if.sv */
`default_nettype none

interface svm_cmd_if;
  logic        valid;
  logic        ready;
  logic [2:0]  cmd;
  logic [2:0]  voice;
  logic [15:0] address;
  logic [7:0]  data_byte;
  logic [15:0] sample_length;
  logic [15:0] loop_start;
  logic [15:0] loop_length;
  logic [6:0]  volume;
  logic [31:0] rate_word;
  logic        pan_left;

  modport source (
    output valid, cmd, voice, address, data_byte, sample_length, loop_start,
           loop_length, volume, rate_word, pan_left,
    input  ready
  );
  modport sink (
    input  valid, cmd, voice, address, data_byte, sample_length, loop_start,
           loop_length, volume, rate_word, pan_left,
    output ready
  );
endinterface

interface svm_res_if;
  logic               valid;
  logic               ready;
  logic               status;
  logic               frame_valid;
  logic signed [10:0] left_sum;
  logic signed [10:0] right_sum;

  modport source (output valid, status, frame_valid, left_sum, right_sum, input ready);
  modport sink   (input valid, status, frame_valid, left_sum, right_sum, output ready);
endinterface

interface svm_cfg_if;
  logic       valid;
  logic       ready;
  logic [2:0] active_voices;

  modport source (output valid, active_voices, input ready);
  modport sink   (input valid, active_voices, output ready);
endinterface

`default_nettype wire

/* src/sample_voice_mixer_unit.sv */
// Sample voice mixer: 64 KiB 8-bit sample store plus four playback voices.
// in_ch carries one command per transaction (write byte, start, stop,
// volume, pan, rate, mix frame); out_ch returns exactly one result per
// command: status, frame flag and the left/right sums of a mixed frame.
// cfg_ch writes active_voices; it is ready outside reset and must be used
// only while no command is in flight.
// From acceptance, a byte write or a rejected/unused command goes straight
// to S_DONE, a voice command passes through S_VMOD first, and a mix frame
// walks the N voices in use before S_DONE (straight to S_DONE when N is
// zero). Mixing visits the voices one after another, each through S_MSMP
// and S_MACC, with the voice state memory read first and then the
// dependent sample memory read.
// A new command is taken once the previous one has been handed to the
// output register, so a pending result does not block input; a stalled
// receiver only holds the next result at its final step.
// Reset stops all voices and sets active_voices to 4; voice state reads as
// its reset values until written. Sample memory is not cleared.
`default_nettype none
`include "assert_macros.svh"

module sample_voice_mixer_unit import svm_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  svm_cmd_if.sink    in_ch,
  svm_res_if.source  out_ch,
  svm_cfg_if.sink    cfg_ch
);

  typedef enum logic [2:0] {S_IDLE, S_VMOD, S_MSMP, S_MACC, S_DONE} state_t;

  state_t state_r;

  logic [2:0] active_r;

  // latched command
  logic [2:0]        cmd_r;
  logic [VIDX_W-1:0] vidx_r;
  logic [15:0]       base_r;
  logic [15:0]       len_r;
  logic [15:0]       lstart_r;
  logic [15:0]       llen_r;
  logic [6:0]        vol_r;
  logic [31:0]       rate_r;
  logic              pan_r;

  // result being built
  logic               status_r;
  logic               frame_r;
  logic signed [10:0] left_r;
  logic signed [10:0] right_r;

  // output register
  logic               out_valid_r;
  logic               out_status_r;
  logic               out_frame_r;
  logic signed [10:0] out_left_r;
  logic signed [10:0] out_right_r;
  logic               out_load;

  // mix walk
  logic [VIDX_W-1:0] idx_r;
  voice_t            vreg_r;
  logic [31:0]       acc_inc_r;

  // memories
  logic [7:0]                  smem [SMEM_DEPTH];
  logic [7:0]                  smem_q_r;
  logic                        s_re;
  logic [SAMPLE_ADDR_BITS-1:0] s_ra;
  logic                        s_we;
  logic [SAMPLE_ADDR_BITS-1:0] s_wa;

  voice_t            vmem [VOICES];
  voice_t            vm_q_r;
  logic              vm_qv_r;
  logic [VOICES-1:0] vvalid_r;
  logic              vm_re;
  logic [VIDX_W-1:0] vm_ra;
  logic              vm_we;
  logic [VIDX_W-1:0] vm_wa;
  voice_t            vm_wd;

  logic             in_ready;
  logic             in_acc;
  logic [LIM_W-1:0] lim;
  logic             reject;
  logic             last;
  voice_t           vcur;
  voice_t           vmod;
  voice_t           vadv;

  logic signed [8:0]  raw;
  logic signed [15:0] prod;
  logic signed [10:0] contrib;
  logic               adv;
  logic [16:0]        nxt;
  logic [16:0]        loop_end;

  assign in_ready    = rst_n && (state_r == S_IDLE);
  assign in_ch.ready = in_ready;
  assign in_acc      = in_ch.valid && in_ready;
  assign cfg_ch.ready = rst_n;

  assign out_ch.valid       = out_valid_r;
  assign out_ch.status      = out_status_r;
  assign out_ch.frame_valid = out_frame_r;
  assign out_ch.left_sum    = out_left_r;
  assign out_ch.right_sum   = out_right_r;

  assign out_load = (state_r == S_DONE) && (!out_valid_r || out_ch.ready);

  assign lim    = (active_r < VOICES) ? LIM_W'(active_r) : LIM_W'(VOICES);
  assign reject = (in_ch.voice >= lim);
  assign last   = ((LIM_W'(idx_r) + 1'b1) == lim);
  assign vcur   = vm_qv_r ? vm_q_r : VOICE_RESET;

  // memory port control
  always_comb begin
    s_we  = in_acc && (in_ch.cmd == CMD_WRITE);
    s_wa  = SAMPLE_ADDR_BITS'(in_ch.address);
    s_re  = (state_r == S_MSMP);
    s_ra  = SAMPLE_ADDR_BITS'(vcur.base + vcur.cursor);
    vm_re = 1'b0;
    vm_ra = '0;
    if (in_acc) begin
      if (in_ch.cmd == CMD_MIX) begin
        vm_re = (lim != '0);
      end else if (in_ch.cmd >= CMD_START && in_ch.cmd <= CMD_RATE) begin
        vm_re = !reject;
        vm_ra = in_ch.voice[VIDX_W-1:0];
      end
    end else if (state_r == S_MACC && !last) begin
      vm_re = 1'b1;
      vm_ra = VIDX_W'(idx_r + 1'b1);
    end
    vm_we = 1'b0;
    vm_wa = vidx_r;
    vm_wd = vmod;
    if (state_r == S_VMOD) begin
      vm_we = 1'b1;
    end else if (state_r == S_MACC) begin
      vm_we = vreg_r.playing;
      vm_wa = idx_r;
      vm_wd = vadv;
    end
  end

  // voice command update
  always_comb begin
    vmod = vcur;
    unique case (cmd_r)
      CMD_START: begin
        vmod.base        = base_r;
        vmod.length      = len_r;
        vmod.loop_start  = lstart_r;
        vmod.loop_length = llen_r;
        vmod.volume      = vol_r;
        vmod.rate        = rate_r;
        vmod.cursor      = '0;
        vmod.acc         = '0;
        vmod.playing     = 1'b1;
      end
      CMD_STOP:   vmod.playing  = 1'b0;
      CMD_VOLUME: vmod.volume   = vol_r;
      CMD_PAN:    vmod.pan_left = pan_r;
      CMD_RATE:   vmod.rate     = rate_r;
      default:    vmod = vcur;
    endcase
  end

  // one voice step of a mix frame
  always_comb begin
    raw      = $signed({1'b0, smem_q_r}) - 9'sd128;
    prod     = raw * $signed({1'b0, vreg_r.volume});
    contrib  = vreg_r.playing ? {prod[15], prod[15:6]} : 11'sd0;
    adv      = (acc_inc_r >= vreg_r.rate);
    loop_end = {1'b0, vreg_r.loop_start} + {1'b0, vreg_r.loop_length};
    nxt      = {1'b0, vreg_r.cursor} + 17'd1;
    vadv     = vreg_r;
    vadv.acc = adv ? (acc_inc_r - vreg_r.rate) : acc_inc_r;
    if (adv) begin
      if (vreg_r.loop_length > LOOP_MIN) begin
        if (nxt >= loop_end) begin
          nxt = {1'b0, vreg_r.loop_start};
        end
      end else if (nxt >= {1'b0, vreg_r.length}) begin
        vadv.playing = 1'b0;
      end
      vadv.cursor = nxt[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (s_we) begin
      smem[s_wa] <= in_ch.data_byte;
    end
    if (s_re) begin
      smem_q_r <= smem[s_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (vm_we) begin
      vmem[vm_wa] <= vm_wd;
    end
    if (vm_re) begin
      vm_q_r  <= vmem[vm_ra];
      vm_qv_r <= vvalid_r[vm_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vvalid_r <= '0;
    end else if (vm_we) begin
      vvalid_r[vm_wa] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= ACTIVE_RESET;
    end else if (cfg_ch.valid) begin
      active_r <= cfg_ch.active_voices;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            cmd_r    <= in_ch.cmd;
            vidx_r   <= in_ch.voice[VIDX_W-1:0];
            base_r   <= in_ch.address;
            len_r    <= in_ch.sample_length;
            lstart_r <= in_ch.loop_start;
            llen_r   <= in_ch.loop_length;
            vol_r    <= clamp_volume(in_ch.volume);
            rate_r   <= in_ch.rate_word;
            pan_r    <= in_ch.pan_left;
            status_r <= 1'b0;
            frame_r  <= 1'b0;
            left_r   <= '0;
            right_r  <= '0;
            idx_r    <= '0;
            unique case (in_ch.cmd)
              CMD_START, CMD_STOP, CMD_VOLUME, CMD_PAN, CMD_RATE: begin
                if (reject) begin
                  status_r <= 1'b1;
                  state_r  <= S_DONE;
                end else begin
                  state_r <= S_VMOD;
                end
              end
              CMD_MIX: begin
                frame_r <= 1'b1;
                state_r <= (lim == '0) ? S_DONE : S_MSMP;
              end
              default: state_r <= S_DONE;
            endcase
          end
        end
        S_VMOD: state_r <= S_DONE;
        S_MSMP: begin
          vreg_r    <= vcur;
          acc_inc_r <= vcur.acc + STEP_INCREMENT;
          state_r   <= S_MACC;
        end
        S_MACC: begin
          if (vreg_r.pan_left) begin
            left_r <= left_r + contrib;
          end else begin
            right_r <= right_r + contrib;
          end
          if (last) begin
            state_r <= S_DONE;
          end else begin
            idx_r   <= VIDX_W'(idx_r + 1'b1);
            state_r <= S_MSMP;
          end
        end
        S_DONE: begin
          // hold until the output register is free
          if (out_load) begin
            out_status_r <= status_r;
            out_frame_r  <= frame_r;
            out_left_r   <= left_r;
            out_right_r  <= right_r;
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  `SVM_ASSERT(a_vmem_rw_apart, vm_we && vm_re |-> vm_wa != vm_ra, "voice memory read and write hit the same entry")
  `SVM_ASSERT_NEXT(a_one_in_flight, in_acc, !in_ready, "second transaction taken while one is in flight")
  `SVM_ASSERT(a_mix_index, (state_r == S_MSMP || state_r == S_MACC) |-> (LIM_W'(idx_r) < lim), "mix walk past the voices in use")
  `SVM_ASSERT(a_frame_status, out_valid_r && out_frame_r |-> !out_status_r, "mixed frame carries a reject status")

endmodule

`default_nettype wire
